### rtl/core/padg_pkg.sv
`default_nettype none

package padg_pkg;

    // Event codes carried in the cmd field.
    typedef enum logic [2:0] {
        CMD_CAPTURE  = 3'd0,
        CMD_MATCH    = 3'd1,
        CMD_OVERFLOW = 3'd2,
        CMD_TIMEOUT  = 3'd3,
        CMD_PIN      = 3'd4
    } cmd_t;

    localparam int unsigned HIST_DEPTH = 6;
    localparam int unsigned HIST_W     = 8;
    localparam int unsigned SUM_W      = 12;
    localparam int unsigned IDX_W      = SUM_W - 3;
    localparam int unsigned ROM_DEPTH  = 256;
    localparam int unsigned ROM_AW     = 8;

    localparam logic [15:0] COMPARE_RESET = 16'hF0F0;

    // Entry 0 is the newest sample; entries 0 and 1 carry weight four.
    typedef logic [HIST_DEPTH-1:0][HIST_W-1:0] hist_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] captured_high;
        logic       pin_level;
    } in_t;

    typedef struct packed {
        logic        drive_level;
        logic [15:0] compare_value;
        logic        compare_updated;
    } out_t;

    localparam logic [15:0] ROM_WORDS [0:ROM_DEPTH-1] = '{
        16'h0000, 16'h0100, 16'h0180, 16'h0200, 16'h0280, 16'h02FF, 16'h0380, 16'h03FF,
        16'h0480, 16'h0500, 16'h0580, 16'h0600, 16'h0680, 16'h0777, 16'h08AA, 16'h09C6,
        16'h0AC4, 16'h0BCC, 16'h0CE0, 16'h0DFF, 16'h0F2A, 16'h1021, 16'h1160, 16'h1266,
        16'h1371, 16'h1482, 16'h1599, 16'h16B5, 16'h17D7, 16'h18FF, 16'h19D5, 16'h1B05,
        16'h1C3B, 16'h1D16, 16'h1E54, 16'h1F32, 16'h2079, 16'h215A, 16'h223B, 16'h238D,
        16'h2471, 16'h2554, 16'h2638, 16'h2799, 16'h287F, 16'h2966, 16'h2A4C, 16'h2BBB,
        16'h2CA4, 16'h2D8D, 16'h2E77, 16'h2F60, 16'h3049, 16'h3132, 16'h32B8, 16'h33A4,
        16'h3490, 16'h357C, 16'h3668, 16'h3754, 16'h3840, 16'h392D, 16'h3ACC, 16'h3BBB,
        16'h3CAA, 16'h3D99, 16'h3E88, 16'h3F77, 16'h4065, 16'h4154, 16'h4243, 16'h4332,
        16'h44F1, 16'h45E3, 16'h46D4, 16'h47C6, 16'h48B8, 16'h49AA, 16'h4A9C, 16'h4B8D,
        16'h4C7F, 16'h4D71, 16'h4E63, 16'h4F54, 16'h5046, 16'h5138, 16'h5321, 16'h5416,
        16'h550A, 16'h55FF, 16'h56F4, 16'h57E8, 16'h58DD, 16'h59D2, 16'h5AC6, 16'h5BBB,
        16'h5CAF, 16'h5DA4, 16'h5E99, 16'h5F8D, 16'h6082, 16'h6177, 16'h626B, 16'h6360,
        16'h6454, 16'h6549, 16'h676E, 16'h6865, 16'h695D, 16'h6A54, 16'h6B4C, 16'h6C43,
        16'h6D3B, 16'h6E32, 16'h6F2A, 16'h7021, 16'h7119, 16'h7210, 16'h7308, 16'h73FF,
        16'h74F6, 16'h75EE, 16'h76E5, 16'h77DD, 16'h78D4, 16'h79CC, 16'h7AC3, 16'h7BBB,
        16'h7CB2, 16'h7DAA, 16'h7EA1, 16'h7F99, 16'h8090, 16'h8188, 16'h827F, 16'h8376,
        16'h85F4, 16'h86EE, 16'h87E8, 16'h88E3, 16'h89DD, 16'h8AD7, 16'h8BD2, 16'h8CCC,
        16'h8DC6, 16'h8EC0, 16'h8FBB, 16'h90B5, 16'h91AF, 16'h92AA, 16'h93A4, 16'h949E,
        16'h9599, 16'h9693, 16'h978D, 16'h9888, 16'h9982, 16'h9A7C, 16'h9B76, 16'h9C71,
        16'h9D6B, 16'h9E65, 16'h9F60, 16'hA05A, 16'hA154, 16'hA24F, 16'hA349, 16'hA443,
        16'hA53E, 16'hA638, 16'hA732, 16'hA82D, 16'hA927, 16'hAA21, 16'hAB1B, 16'hAC16,
        16'hAD10, 16'hAE0A, 16'hAF05, 16'hAFFF, 16'hB0F9, 16'hB1F4, 16'hB2EE, 16'hB3E8,
        16'hB4E3, 16'hB5DD, 16'hB6D7, 16'hB7D2, 16'hB8CC, 16'hB9C6, 16'hBAC0, 16'hBDDD,
        16'hBEDA, 16'hBFD7, 16'hC0D4, 16'hC1D2, 16'hC2CF, 16'hC3CC, 16'hC4C9, 16'hC5C6,
        16'hC6C3, 16'hC7C0, 16'hC8BE, 16'hC9BB, 16'hCAB8, 16'hCBB5, 16'hCCB2, 16'hCDAF,
        16'hCEAD, 16'hCFAA, 16'hD0A7, 16'hD1A4, 16'hD2A1, 16'hD39E, 16'hD49B, 16'hD599,
        16'hD696, 16'hD793, 16'hD890, 16'hD98D, 16'hDA8A, 16'hDB88, 16'hDC85, 16'hDD82,
        16'hDE7F, 16'hDF7C, 16'hE079, 16'hE176, 16'hE274, 16'hE371, 16'hE46E, 16'hE56B,
        16'hE668, 16'hE765, 16'hE863, 16'hE960, 16'hEA5D, 16'hEB5A, 16'hEC57, 16'hED54,
        16'hEE52, 16'hEF4F, 16'hF04C, 16'hF149, 16'hF246, 16'hF343, 16'hF440, 16'hF53E,
        16'hF63B, 16'hF738, 16'hF835, 16'hF932, 16'hFA2F, 16'hFB2D, 16'hFC2A, 16'hFD27
    };

endpackage

`default_nettype wire

### rtl/core/padg_ram.sv
`default_nettype none

// Simple dual-port RAM, one write port and one registered read port.
module padg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/period_averaged_delay_gate_unit.sv
`default_nettype none

// Channel  Direction  Ports                      Contents
// s_       in         s_valid s_ready s_data     one timing event (cmd, byte, pin)
// m_       out        m_valid m_ready m_data     drive level, compare value, update flag
//
// Each event yields exactly one result transaction, via the decode and output registers.
// One event per cycle is sustained while m_ready is high; the history memory is read at
// accept and written back when an armed capture leaves decode, with a forward path for
// back-to-back use. aresetn is synchronous and active low; the history memory reads as
// zero until written. A stalled result holds the decode stage, which holds s_ready low.
module period_averaged_delay_gate_unit #(
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire padg_pkg::in_t s_data,

    output logic               m_valid,
    input  wire logic          m_ready,
    output padg_pkg::out_t     m_data
);

    import padg_pkg::*;

    // The averaged index saturates at the last table entry that exists, and the
    // table never holds more than ROM_DEPTH words.
    localparam int unsigned IDX_TOP =
        ((TABLE_ENTRIES - 1) < (ROM_DEPTH - 1)) ? (TABLE_ENTRIES - 1) : (ROM_DEPTH - 1);

    // Decode stage: the accepted event waits here for the history read data.
    logic  p1_valid_reg;
    in_t   p1_data_reg;
    logic  p1_adv;

    // Output register.
    logic  out_valid_reg;
    out_t  out_data_reg;

    // Control state kept in flip-flops.
    logic        armed_reg,   armed_next;
    logic        firing_reg,  firing_next;
    logic        forced_reg,  forced_next;
    logic        timeout_reg, timeout_next;
    logic        drive_reg,   drive_next;
    logic [15:0] compare_reg, compare_next;
    logic        updated;

    // History memory and its forward path.
    logic        hist_valid_reg;
    logic        fwd_hit_reg;
    hist_t       fwd_data_reg;
    hist_t       ram_rd_data;
    hist_t       hist_cur;
    hist_t       hist_shift;
    logic        ram_we;
    logic        s_accept;

    logic [SUM_W-1:0]  avg_sum;
    logic [IDX_W-1:0]  avg_idx;
    logic [ROM_AW-1:0] rom_idx;

    assign p1_adv   = p1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || p1_adv;
    assign s_accept = s_valid && s_ready;

    // The whole six-entry history is one memory word, read when a transaction is
    // accepted and written back when an armed capture edge retires.
    padg_ram #(
        .WIDTH ($bits(hist_t)),
        .DEPTH (1)
    ) u_hist_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (1'b0),
        .wr_data (hist_shift),
        .rd_en   (s_accept),
        .rd_addr (1'b0),
        .rd_data (ram_rd_data)
    );

    // A write that lands on the same edge as the read is not seen by the read,
    // so its data is forwarded. Before the first write the memory reads as zero.
    always_comb begin
        if (fwd_hit_reg) begin
            hist_cur = fwd_data_reg;
        end else if (hist_valid_reg) begin
            hist_cur = ram_rd_data;
        end else begin
            hist_cur = '0;
        end
    end

    always_comb begin
        hist_shift = {hist_cur[HIST_DEPTH-2:0], p1_data_reg.captured_high};
    end

    // Weighted average: the two newest entries count four times.
    always_comb begin
        avg_sum = ({4'b0000, hist_shift[0]} + {4'b0000, hist_shift[1]}) * 12'd4
                + {4'b0000, hist_shift[2]} + {4'b0000, hist_shift[3]}
                + {4'b0000, hist_shift[4]} + {4'b0000, hist_shift[5]};
        avg_idx = avg_sum[SUM_W-1:3];
        if (avg_idx > IDX_W'(IDX_TOP)) begin
            rom_idx = ROM_AW'(IDX_TOP);
        end else begin
            rom_idx = avg_idx[ROM_AW-1:0];
        end
    end

    // Event decode.
    always_comb begin
        armed_next   = armed_reg;
        firing_next  = firing_reg;
        forced_next  = forced_reg;
        timeout_next = timeout_reg;
        drive_next   = drive_reg;
        compare_next = compare_reg;
        updated      = 1'b0;
        ram_we       = 1'b0;
        case (p1_data_reg.cmd)
            CMD_CAPTURE: begin
                forced_next  = 1'b0;
                timeout_next = 1'b0;
                if (armed_reg) begin
                    firing_next  = 1'b1;
                    compare_next = ROM_WORDS[rom_idx];
                    updated      = 1'b1;
                    ram_we       = p1_adv;
                end else begin
                    // The first edge after an overflow only arms the gate.
                    armed_next = 1'b1;
                end
            end
            CMD_MATCH: begin
                if (firing_reg && armed_reg) begin
                    forced_next = 1'b1;
                    drive_next  = 1'b1;
                end
            end
            CMD_OVERFLOW: begin
                firing_next = 1'b0;
                armed_next  = 1'b0;
                forced_next = 1'b0;
            end
            CMD_TIMEOUT: begin
                timeout_next = 1'b1;
                drive_next   = 1'b1;
            end
            CMD_PIN: begin
                // The timeout latch holds the drive high until the next capture edge.
                if (!timeout_reg) begin
                    drive_next = forced_reg | p1_data_reg.pin_level;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            armed_reg      <= 1'b0;
            firing_reg     <= 1'b0;
            forced_reg     <= 1'b0;
            timeout_reg    <= 1'b0;
            drive_reg      <= 1'b0;
            compare_reg    <= COMPARE_RESET;
            hist_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                p1_valid_reg <= 1'b1;
                fwd_hit_reg  <= ram_we;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv) begin
                out_valid_reg <= 1'b1;
                armed_reg     <= armed_next;
                firing_reg    <= firing_next;
                forced_reg    <= forced_next;
                timeout_reg   <= timeout_next;
                drive_reg     <= drive_next;
                compare_reg   <= compare_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we) begin
                hist_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_data_reg  <= s_data;
            fwd_data_reg <= hist_shift;
        end
        if (p1_adv) begin
            out_data_reg.drive_level     <= drive_next;
            out_data_reg.compare_value   <= compare_next;
            out_data_reg.compare_updated <= updated;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    // While the timeout latch is set, the drive must be held high.
    a_timeout_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        timeout_reg |-> drive_reg)
        else $error("timeout latch set with drive low");

    // The compare value cannot leave its reset value before the history is written.
    a_compare_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !hist_valid_reg |-> (compare_reg == COMPARE_RESET))
        else $error("compare value changed without a history write");

    // A history write comes from an armed capture edge, which leaves the gate firing.
    a_write_fires: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (firing_reg && armed_reg && hist_valid_reg))
        else $error("history written without arming and firing");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

// Self-checking bench for the period averaged delay gate. Every timing event is
// pushed through the input channel and mirrored into a local model of the gate
// at the moment the transaction is accepted. The model turns the event into the
// result that the block must return. A checking process compares each result
// transaction, field by field, against the oldest outstanding prediction.
module tb_top;
    import padg_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 256;
    localparam int unsigned RANDOM_EVENTS = 400;
    localparam int unsigned DRAIN_CYCLES  = 8;

    // Codes that the block must treat as no-ops.
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    period_averaged_delay_gate_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Local copy of the gate state. Entry 0 of each history array is the newest.
    logic [7:0]  recent_hist [2];
    logic [7:0]  older_hist  [4];
    logic        armed;
    logic        firing;
    logic        forced;
    logic        timeout_held;
    logic        drive_bit;
    logic [15:0] compare_word;

    // Results that the block still owes, oldest first.
    out_t        pending_results [$];
    int unsigned mismatch_count;
    int unsigned events_sent;

    // Remaining length of an idle-free stretch, one counter per channel.
    int unsigned quiet_left [2];

    always #1 aclk = ~aclk;

    // Hard stop in case the block stops accepting or returning transactions.
    initial begin
        #1000000;
        $display("period_averaged_delay_gate_unit verification failed");
        $finish;
    end

    // Idle length for one channel: mostly none or short, now and then long, and
    // from time to time a longer stretch in which the channel never idles at all.
    function automatic int unsigned pick_gap(input int side);
        int unsigned roll;
        if (quiet_left[side] != 0) begin
            quiet_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Period bytes lean toward the top of the range so that the averaged index
    // runs past the end of the table often, but every value stays reachable.
    function automatic logic [7:0] rand_period_byte();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        if (roll < 35) return 8'($urandom_range(200, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic in_t make_event(input logic [2:0] code, input logic [7:0] period_byte,
                                       input logic pin);
        in_t ev;
        ev.cmd           = code;
        ev.captured_high = period_byte;
        ev.pin_level     = pin;
        return ev;
    endfunction

    // Event with the given code and random contents in its byte and pin fields.
    function automatic in_t rand_fields_event(input logic [2:0] code);
        return make_event(code, rand_period_byte(), 1'($urandom_range(0, 1)));
    endfunction

    // Advance the local model by one event and queue the result it produces.
    task automatic predict_gate_event(input in_t ev);
        int unsigned weighted_sum;
        int unsigned rom_index;
        out_t        result;
        result.compare_updated = 1'b0;
        case (ev.cmd)
            CMD_CAPTURE: begin
                forced       = 1'b0;
                timeout_held = 1'b0;
                if (armed) begin
                    firing         = 1'b1;
                    older_hist[3]  = older_hist[2];
                    older_hist[2]  = older_hist[1];
                    older_hist[1]  = older_hist[0];
                    older_hist[0]  = recent_hist[1];
                    recent_hist[1] = recent_hist[0];
                    recent_hist[0] = ev.captured_high;
                    weighted_sum = (int'(recent_hist[0]) + int'(recent_hist[1])) * 4
                                 + older_hist[0] + older_hist[1]
                                 + older_hist[2] + older_hist[3];
                    rom_index = weighted_sum >> 3;
                    // The index can climb to 382; it saturates at the last word.
                    if (rom_index > TABLE_ENTRIES - 1) rom_index = TABLE_ENTRIES - 1;
                    if (rom_index > ROM_DEPTH - 1) rom_index = ROM_DEPTH - 1;
                    compare_word = ROM_WORDS[rom_index];
                    result.compare_updated = 1'b1;
                end else begin
                    armed = 1'b1;
                end
            end
            CMD_MATCH: begin
                if (firing && armed) begin
                    forced    = 1'b1;
                    drive_bit = 1'b1;
                end
            end
            CMD_OVERFLOW: begin
                firing = 1'b0;
                armed  = 1'b0;
                forced = 1'b0;
            end
            CMD_TIMEOUT: begin
                timeout_held = 1'b1;
                drive_bit    = 1'b1;
            end
            CMD_PIN: begin
                if (!timeout_held) drive_bit = forced ? 1'b1 : ev.pin_level;
            end
            default: begin
            end
        endcase
        result.drive_level   = drive_bit;
        result.compare_value = compare_word;
        pending_results.push_back(result);
    endtask

    // Offer one event on the input channel. The task is entered just after a
    // rising edge; it changes the inputs at the next falling edge, possibly after
    // an idle gap, and holds valid and the payload until the transaction is
    // accepted. Valid is never dropped between back-to-back transactions.
    task automatic drive_event(input in_t ev);
        int unsigned gap;
        gap = pick_gap(0);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = ev;
        do @(posedge aclk); while (!s_ready);
        predict_gate_event(ev);
        events_sent++;
    endtask

    // Result side: compare every accepted transaction with the oldest prediction.
    always @(posedge aclk) begin
        out_t wanted;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %p", $time, m_data);
                mismatch_count++;
            end else begin
                wanted = pending_results.pop_front();
                if (m_data.drive_level !== wanted.drive_level) begin
                    $display("%0t: drive_level expected %0b actual %0b",
                             $time, wanted.drive_level, m_data.drive_level);
                    mismatch_count++;
                end
                if (m_data.compare_value !== wanted.compare_value) begin
                    $display("%0t: compare_value expected %h actual %h",
                             $time, wanted.compare_value, m_data.compare_value);
                    mismatch_count++;
                end
                if (m_data.compare_updated !== wanted.compare_updated) begin
                    $display("%0t: compare_updated expected %0b actual %0b",
                             $time, wanted.compare_updated, m_data.compare_updated);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver back-pressure. Ready changes only at falling edges, with random
    // stalls between short stretches of readiness.
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = pick_gap(1);
            if (stall != 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 6) - 1) @(negedge aclk);
        end
    end

    // Unused codes and a compare match while the gate is not armed must leave the
    // state alone; the pin samples that follow copy the pin level to the drive.
    task automatic test_idle_events();
        drive_event(make_event(CMD_SPARE_LO, 8'hFF, 1'b1));
        drive_event(make_event(CMD_SPARE_MID, 8'h00, 1'b0));
        drive_event(make_event(CMD_SPARE_HI, 8'hA5, 1'b1));
        drive_event(make_event(CMD_MATCH, 8'h5A, 1'b1));
        drive_event(make_event(CMD_PIN, 8'hFF, 1'b1));
        drive_event(make_event(CMD_PIN, 8'h00, 1'b0));
    endtask

    // The first capture edge only arms the gate; the following ones fill the
    // history. Six full-scale bytes push the index well past the table end.
    task automatic test_arming_and_saturation();
        drive_event(make_event(CMD_CAPTURE, 8'h12, 1'b0));
        repeat (6) drive_event(make_event(CMD_CAPTURE, 8'hFF, 1'b1));
        drive_event(make_event(CMD_CAPTURE, 8'h00, 1'b0));
        drive_event(make_event(CMD_CAPTURE, 8'h00, 1'b1));
    endtask

    // A compare match while firing holds the drive high through pin samples.
    // A capture edge clears the force but leaves the drive until the next sample.
    // A period overflow disarms the gate, so a later match has no effect.
    task automatic test_forced_drive();
        drive_event(make_event(CMD_MATCH, 8'h00, 1'b0));
        drive_event(make_event(CMD_PIN, 8'h00, 1'b0));
        drive_event(make_event(CMD_CAPTURE, 8'h80, 1'b0));
        drive_event(make_event(CMD_PIN, 8'h00, 1'b0));
        drive_event(make_event(CMD_OVERFLOW, 8'hFF, 1'b1));
        drive_event(make_event(CMD_MATCH, 8'hFF, 1'b1));
        drive_event(make_event(CMD_PIN, 8'hFF, 1'b0));
    endtask

    // A gap timeout drives high and masks pin samples until the next capture edge.
    task automatic test_gap_timeout();
        drive_event(make_event(CMD_TIMEOUT, 8'h00, 1'b0));
        drive_event(make_event(CMD_PIN, 8'h00, 1'b0));
        drive_event(make_event(CMD_CAPTURE, 8'h33, 1'b0));
        drive_event(make_event(CMD_PIN, 8'h00, 1'b0));
    endtask

    // Mostly well-formed sessions: an overflow, an arming edge, then a run of
    // captures, matches, pin samples and the odd timeout. The rest is noise that
    // uses every code with random contents.
    task automatic test_random_sessions();
        int unsigned steps;
        int unsigned roll;
        while (events_sent < RANDOM_EVENTS + 25) begin
            if ($urandom_range(0, 99) < 80) begin
                drive_event(rand_fields_event(CMD_OVERFLOW));
                drive_event(rand_fields_event(CMD_CAPTURE));
                steps = $urandom_range(1, 12);
                repeat (steps) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 40)      drive_event(rand_fields_event(CMD_CAPTURE));
                    else if (roll < 60) drive_event(rand_fields_event(CMD_MATCH));
                    else if (roll < 85) drive_event(rand_fields_event(CMD_PIN));
                    else if (roll < 90) drive_event(rand_fields_event(CMD_TIMEOUT));
                    else drive_event(rand_fields_event(3'($urandom_range(0, 7))));
                end
            end else begin
                repeat ($urandom_range(1, 10))
                    drive_event(rand_fields_event(3'($urandom_range(0, 7))));
            end
        end
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        mismatch_count = 0;
        events_sent    = 0;
        quiet_left[0]  = 0;
        quiet_left[1]  = 0;

        // Model state after reset.
        recent_hist  = '{default: 8'h00};
        older_hist   = '{default: 8'h00};
        armed        = 1'b0;
        firing       = 1'b0;
        forced       = 1'b0;
        timeout_held = 1'b0;
        drive_bit    = 1'b0;
        compare_word = COMPARE_RESET;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        test_idle_events();
        test_arming_and_saturation();
        test_forced_drive();
        test_gap_timeout();
        test_random_sessions();

        @(negedge aclk);
        s_valid = 1'b0;

        // Every event owes exactly one result, so the queue empties once the
        // block has caught up; a drain period after that catches any stray transaction.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("period_averaged_delay_gate_unit verification clean");
        end else begin
            $display("period_averaged_delay_gate_unit verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
